// ===== rtl/mvmg_pkg.sv =====
package mvmg_pkg;

  localparam int VOICE_COUNT      = 8;
  localparam int INSTRUMENT_COUNT = 25;
  localparam int ROM_ENTRIES      = 25;
  localparam int ROM_IDX_W        = $clog2(ROM_ENTRIES);
  localparam int VIDX_W           = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int BEND_W           = 3;

  // Command codes
  localparam logic [2:0] FN_NOTE_ON  = 3'd0;
  localparam logic [2:0] FN_NOTE_OFF = 3'd1;
  localparam logic [2:0] FN_INSTR    = 3'd2;
  localparam logic [2:0] FN_PLAY     = 3'd3;
  localparam logic [2:0] FN_STOP     = 3'd4;

  // Voice kinds
  localparam logic [1:0] KIND_SILENT  = 2'd0;
  localparam logic [1:0] KIND_MELODIC = 2'd1;
  localparam logic [1:0] KIND_PERC    = 2'd2;

  // Register indexes
  localparam logic REG_IDX_BANK = 1'b0;

  // MIDI bytes
  localparam logic [7:0] NO_NOTE      = 8'hFF;
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_CONTROL   = 8'hB0;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;
  localparam logic [7:0] ST_BEND      = 8'hE0;
  localparam logic [7:0] CTRL_ALL_OFF = 8'h7B;
  localparam logic [7:0] CTRL_VOLUME  = 8'h07;
  localparam logic [7:0] BEND_CENTRE  = 8'h40;
  localparam logic [3:0] PERC_CHANNEL = 4'd9;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] patch;
    logic [7:0] shift;
    logic [6:0] attack;
    logic [6:0] rel_vel;
    logic [6:0] level;
  } rom_entry_t;

  localparam rom_entry_t INSTR_ROM [2][ROM_ENTRIES] = '{
    '{
      '{2'd1, 7'd34,  8'd0,  7'h7F, 7'h7F, 7'h5F}, '{2'd1, 7'd37,  8'd0,  7'h3F, 7'h3F, 7'h4F},
      '{2'd1, 7'd34,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd116, 8'd50, 7'h7F, 7'h7F, 7'h7F},
      '{2'd1, 7'd3,   8'd24, 7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd38,  8'd0,  7'h4F, 7'h4F, 7'h4F},
      '{2'd1, 7'd7,   8'd0,  7'h5F, 7'h5F, 7'h6F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h7F},
      '{2'd2, 7'd40,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd127, 8'd40, 7'h6F, 7'h6F, 7'h6F},
      '{2'd1, 7'd122, 8'd40, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd44,  8'd0,  7'h7F, 7'h7F, 7'h3F},
      '{2'd1, 7'd122, 8'd72, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd37,  8'd0,  7'h7F, 7'h7F, 7'h7F},
      '{2'd2, 7'd62,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd115, 8'd57, 7'h7F, 7'h7F, 7'h7F},
      '{2'd1, 7'd117, 8'd81, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd39,  8'd0,  7'h7F, 7'h7F, 7'h7F},
      '{2'd1, 7'd127, 8'd40, 7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd73,  8'd24, 7'h7F, 7'h20, 7'h7F},
      '{2'd1, 7'd118, 8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h5F},
      '{2'd2, 7'd56,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd38,  8'd0,  7'h7F, 7'h7F, 7'h3F},
      '{2'd1, 7'd11,  8'd36, 7'h7F, 7'h20, 7'h7F}
    },
    '{
      '{2'd1, 7'd28,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd69,  8'd0,  7'h3F, 7'h3F, 7'h3F},
      '{2'd1, 7'd28,  8'd0,  7'h7F, 7'h7F, 7'h78}, '{2'd1, 7'd117, 8'd50, 7'h7F, 7'h7F, 7'h7F},
      '{2'd1, 7'd7,   8'd24, 7'h5F, 7'h7F, 7'h6F}, '{2'd1, 7'd30,  8'd0,  7'h5F, 7'h5F, 7'h5F},
      '{2'd1, 7'd16,  8'd0,  7'h4F, 7'h4F, 7'h6F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h7F},
      '{2'd2, 7'd40,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd114, 8'd28, 7'h6F, 7'h6F, 7'h6F},
      '{2'd1, 7'd119, 8'd52, 7'h2F, 7'h7F, 7'h7F}, '{2'd2, 7'd44,  8'd0,  7'h7F, 7'h7F, 7'h3F},
      '{2'd1, 7'd124, 8'd60, 7'h7F, 7'h7F, 7'h5F}, '{2'd2, 7'd37,  8'd0,  7'h7F, 7'h7F, 7'h7F},
      '{2'd2, 7'd62,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd120, 8'd57, 7'h7F, 7'h7F, 7'h7F},
      '{2'd1, 7'd113, 8'd81, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd39,  8'd0,  7'h7F, 7'h7F, 7'h7F},
      '{2'd1, 7'd114, 8'd28, 7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd47,  8'd25, 7'h7F, 7'h20, 7'h7F},
      '{2'd1, 7'd64,  8'd0,  7'h7F, 7'h7F, 7'h4F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h5F},
      '{2'd2, 7'd56,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd40,  8'd0,  7'h7F, 7'h7F, 7'h5F},
      '{2'd1, 7'd38,  8'd25, 7'h7F, 7'h20, 7'h7F}
    }
  };

  function automatic logic instr_valid(input logic [7:0] idx);
    return (32'(idx) < INSTRUMENT_COUNT) && (32'(idx) < ROM_ENTRIES);
  endfunction

  function automatic rom_entry_t rom_read(input logic bank, input logic [7:0] idx);
    rom_entry_t e;
    e = '0;
    if (32'(idx) < ROM_ENTRIES) begin
      e = INSTR_ROM[bank][ROM_IDX_W'(idx)];
    end
    return e;
  endfunction

  // Byte groups the datapath can emit
  typedef enum logic [2:0] {
    SEG_REL    = 3'd0,
    SEG_VOL    = 3'd1,
    SEG_ON     = 3'd2,
    SEG_PRG    = 3'd3,
    SEG_BEND   = 3'd4,
    SEG_ALLOFF = 3'd5
  } seg_e;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHECK  = 10'b00_0000_0010,
    S_REL    = 10'b00_0000_0100,
    S_LOAD   = 10'b00_0000_1000,
    S_VOL    = 10'b00_0001_0000,
    S_ON     = 10'b00_0010_0000,
    S_PRG    = 10'b00_0100_0000,
    S_BEND   = 10'b00_1000_0000,
    S_SCAN   = 10'b01_0000_0000,
    S_ALLOFF = 10'b10_0000_0000
  } ctl_state_e;

  typedef struct packed {
    logic       start;
    logic       scan_init;
    logic       scan_next;
    logic       bend_next;
    logic       load_voice;
    logic       clr_held;
    logic       set_held;
    logic       emit;
    logic       last;
    seg_e       seg;
    logic [1:0] idx;
  } vm_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       voice_ok;
    logic       held;
    logic [1:0] kind;
    logic       instr_ok;
    logic       instr_mel;
    logic       scan_last;
    logic       bend_last;
    logic       can_emit;
  } vm_status_t;

endpackage

// ===== rtl/mvmg_dp.sv =====
module mvmg_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [2:0]           func_i,
  input  logic [2:0]           voice_i,
  input  logic [7:0]           value_i,
  input  logic [3:0]           current_channel_i,
  input  logic                 bank_i,
  input  mvmg_pkg::vm_cmd_t    cmd_i,
  output mvmg_pkg::vm_status_t st_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [7:0]           midi_byte_o,
  output logic                 last_byte_o,
  output logic [3:0]           channel_out_o
);
  import mvmg_pkg::*;

  // Per-voice state
  logic [7:0] held_q    [VOICE_COUNT];
  logic [3:0] chan_q    [VOICE_COUNT];
  logic [1:0] kind_q    [VOICE_COUNT];
  logic [6:0] patch_q   [VOICE_COUNT];
  logic [7:0] shift_q   [VOICE_COUNT];
  logic [6:0] attack_q  [VOICE_COUNT];
  logic [6:0] rel_vel_q [VOICE_COUNT];
  logic [6:0] level_q   [VOICE_COUNT];

  // Latched request
  logic [2:0]  func_q;
  logic [7:0]  value_q;
  logic [3:0]  cmd_ch_q;
  logic [3:0]  ch_out_q;
  logic        voice_ok_q;
  logic        instr_ok_q;
  rom_entry_t  rom_q;

  logic [VIDX_W-1:0] vsel_q;
  logic [BEND_W-1:0] bend_q;

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [3:0] chan_out_q;

  rom_entry_t rom_sel;
  logic       rom_ok;
  logic [3:0] mel_ch;
  logic [3:0] ch_out_d;
  logic [3:0] rel_ch;
  logic [7:0] note;
  logic [7:0] byte_d;

  assign rom_sel = rom_read(bank_i, value_i);
  assign rom_ok  = instr_valid(value_i);
  assign mel_ch  = {1'b0, voice_i} + {3'b000, bank_i};

  always_comb begin
    ch_out_d = current_channel_i;
    if (func_i == FN_INSTR && rom_ok) begin
      ch_out_d = (rom_sel.kind == KIND_MELODIC) ? mel_ch : PERC_CHANNEL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q     <= func_i;
      value_q    <= value_i;
      cmd_ch_q   <= current_channel_i;
      ch_out_q   <= ch_out_d;
      voice_ok_q <= (32'(voice_i) < VOICE_COUNT);
      instr_ok_q <= rom_ok;
      rom_q      <= rom_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsel_q <= '0;
      bend_q <= '0;
    end else begin
      if (cmd_i.start) begin
        vsel_q <= VIDX_W'(voice_i);
        bend_q <= '0;
      end else if (cmd_i.scan_init) begin
        vsel_q <= '0;
      end else if (cmd_i.scan_next) begin
        vsel_q <= vsel_q + VIDX_W'(1);
      end
      if (cmd_i.bend_next) begin
        bend_q <= bend_q + BEND_W'(1);
      end
    end
  end

  // Percussion plays its patch as the note
  assign note   = (kind_q[vsel_q] == KIND_PERC) ? {1'b0, patch_q[vsel_q]}
                                                : value_q + shift_q[vsel_q];
  assign rel_ch = (func_q == FN_STOP) ? chan_q[vsel_q] : cmd_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        held_q[i]    <= NO_NOTE;
        chan_q[i]    <= '0;
        kind_q[i]    <= KIND_SILENT;
        patch_q[i]   <= '0;
        shift_q[i]   <= '0;
        attack_q[i]  <= '0;
        rel_vel_q[i] <= '0;
        level_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.clr_held) begin
        held_q[vsel_q] <= NO_NOTE;
      end else if (cmd_i.set_held) begin
        held_q[vsel_q] <= note[7] ? NO_NOTE : note;
      end
      if (cmd_i.load_voice) begin
        chan_q[vsel_q]    <= ch_out_q;
        kind_q[vsel_q]    <= rom_q.kind;
        patch_q[vsel_q]   <= rom_q.patch;
        shift_q[vsel_q]   <= rom_q.shift;
        attack_q[vsel_q]  <= rom_q.attack;
        rel_vel_q[vsel_q] <= rom_q.rel_vel;
        level_q[vsel_q]   <= rom_q.level;
      end
    end
  end

  always_comb begin
    byte_d = '0;
    case (cmd_i.seg)
      SEG_REL: begin
        case (cmd_i.idx)
          2'd0:    byte_d = ST_NOTE_OFF | {4'h0, rel_ch};
          2'd1:    byte_d = held_q[vsel_q];
          default: byte_d = {1'b0, rel_vel_q[vsel_q]};
        endcase
      end
      SEG_VOL: begin
        case (cmd_i.idx)
          2'd0:    byte_d = ST_CONTROL | {4'h0, ch_out_q};
          2'd1:    byte_d = CTRL_VOLUME;
          default: byte_d = {1'b0, level_q[vsel_q]};
        endcase
      end
      SEG_ON: begin
        case (cmd_i.idx)
          2'd0:    byte_d = ST_NOTE_ON | {4'h0, ch_out_q};
          2'd1:    byte_d = note;
          default: byte_d = {1'b0, attack_q[vsel_q]};
        endcase
      end
      SEG_PRG: begin
        case (cmd_i.idx)
          2'd0:    byte_d = ST_PROGRAM | {4'h0, ch_out_q};
          default: byte_d = {1'b0, patch_q[vsel_q]};
        endcase
      end
      SEG_BEND: begin
        case (cmd_i.idx)
          2'd0:    byte_d = ST_BEND | {5'b00000, bend_q};
          2'd1:    byte_d = 8'h00;
          default: byte_d = BEND_CENTRE;
        endcase
      end
      SEG_ALLOFF: begin
        case (cmd_i.idx)
          2'd0:    byte_d = ST_CONTROL;
          2'd1:    byte_d = CTRL_ALL_OFF;
          default: byte_d = 8'h00;
        endcase
      end
      default: byte_d = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      byte_q     <= byte_d;
      last_q     <= cmd_i.last;
      chan_out_q <= ch_out_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign midi_byte_o   = byte_q;
  assign last_byte_o   = last_q;
  assign channel_out_o = chan_out_q;

  always_comb begin
    st_o           = '0;
    st_o.func      = func_q;
    st_o.voice_ok  = voice_ok_q;
    st_o.held      = ~held_q[vsel_q][7];
    st_o.kind      = kind_q[vsel_q];
    st_o.instr_ok  = instr_ok_q;
    st_o.instr_mel = (rom_q.kind == KIND_MELODIC);
    st_o.scan_last = (vsel_q == VIDX_W'(VOICE_COUNT - 1));
    st_o.bend_last = (bend_q == {BEND_W{1'b1}});
    st_o.can_emit  = ~out_valid_q | out_ready_i;
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_i.emit)
    else $error("byte issued over a stalled output byte");

endmodule

// ===== rtl/mvmg_ctrl.sv =====
module mvmg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mvmg_pkg::vm_status_t st_i,
  output mvmg_pkg::vm_cmd_t    cmd_o
);
  import mvmg_pkg::*;

  ctl_state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  logic       emitting;
  seg_e       seg;
  logic [1:0] seg_end;
  ctl_state_e nxt;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    emitting = 1'b0;
    seg      = SEG_REL;
    seg_end  = 2'd2;
    nxt      = S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d = '0;
        if (!st_i.voice_ok) begin
          state_d = S_IDLE;
        end else begin
          case (st_i.func)
            FN_NOTE_ON: begin
              if (st_i.held)                    state_d = S_REL;
              else if (st_i.kind == KIND_SILENT) state_d = S_IDLE;
              else if (st_i.kind == KIND_PERC)   state_d = S_VOL;
              else                               state_d = S_ON;
            end
            FN_NOTE_OFF: state_d = st_i.held ? S_REL : S_IDLE;
            FN_INSTR: begin
              if (!st_i.instr_ok) state_d = S_IDLE;
              else if (st_i.held) state_d = S_REL;
              else                state_d = S_LOAD;
            end
            FN_PLAY: state_d = S_BEND;
            FN_STOP: begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cnt_d = '0;
        if (st_i.held) begin
          state_d = S_REL;
        end else if (st_i.scan_last) begin
          state_d = S_ALLOFF;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_LOAD: begin
        cmd_o.load_voice = 1'b1;
        state_d          = st_i.instr_mel ? S_PRG : S_IDLE;
      end
      S_REL: begin
        emitting = 1'b1;
        seg      = SEG_REL;
        case (st_i.func)
          FN_NOTE_ON: begin
            if (st_i.kind == KIND_SILENT)    nxt = S_IDLE;
            else if (st_i.kind == KIND_PERC) nxt = S_VOL;
            else                             nxt = S_ON;
          end
          FN_INSTR: nxt = S_LOAD;
          FN_STOP:  nxt = st_i.scan_last ? S_ALLOFF : S_SCAN;
          default:  nxt = S_IDLE;
        endcase
      end
      S_VOL: begin
        emitting = 1'b1;
        seg      = SEG_VOL;
        nxt      = (st_i.func == FN_NOTE_ON) ? S_ON : S_IDLE;
      end
      S_ON: begin
        emitting = 1'b1;
        seg      = SEG_ON;
        nxt      = S_IDLE;
      end
      S_PRG: begin
        emitting = 1'b1;
        seg      = SEG_PRG;
        seg_end  = 2'd1;
        nxt      = S_VOL;
      end
      S_BEND: begin
        emitting = 1'b1;
        seg      = SEG_BEND;
        nxt      = st_i.bend_last ? S_IDLE : S_BEND;
      end
      S_ALLOFF: begin
        emitting = 1'b1;
        seg      = SEG_ALLOFF;
        nxt      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // One byte per cycle while the output register can take it
    if (emitting && st_i.can_emit) begin
      cmd_o.emit = 1'b1;
      cmd_o.seg  = seg;
      cmd_o.idx  = cnt_q;
      if (cnt_q == seg_end) begin
        cnt_d           = '0;
        state_d         = nxt;
        cmd_o.last      = (nxt == S_IDLE) || (nxt == S_LOAD && !st_i.instr_mel);
        cmd_o.clr_held  = (seg == SEG_REL);
        cmd_o.set_held  = (seg == SEG_ON);
        cmd_o.bend_next = (seg == SEG_BEND);
        cmd_o.scan_next = (seg == SEG_REL) && (st_i.func == FN_STOP) && !st_i.scan_last;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // A percussive load still passes through the load state after its final byte
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> (state_q == S_IDLE || state_q == S_LOAD))
    else $error("final byte issued but request still running");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CHECK)
    else $error("accepted request did not enter decode");

endmodule

// ===== rtl/midi_voice_message_generator.sv =====
// A request is latched on acceptance, decoded in the check state, and each byte it sends is
// registered in the output register. Throughput: one byte per cycle while the sink is ready;
// a new request is accepted only in idle, once the previous one (including an instrument load
// and the voice scan on stop-all) is done, also when it sends nothing.
// Reset (rst_ni low, asynchronous): bank 0, no notes held, all voices silent on channel 0,
// output register empty.
module midi_voice_message_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [2:0]  voice_i,
  input  logic [7:0]  value_i,
  input  logic [3:0]  current_channel_i,
  // MIDI byte requests
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  midi_byte_o,
  output logic        last_byte_o,
  output logic [3:0]  channel_out_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mvmg_pkg::*;

  logic       bank_q;
  logic       cfg_wr;
  vm_cmd_t    cmd;
  vm_status_t st;

  // Configuration: a single bank-select bit, selected while address bit 2 is clear (byte
  // addresses 0 to 3). Writes land on the access phase; the port never stalls.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_IDX_BANK) begin
      bank_q <= pwdata[0];
    end
  end

  // Reads with address bit 2 set return zero
  assign prdata = (paddr[2] == REG_IDX_BANK) ? {31'b0, bank_q} : 32'b0;

  // Sequencer: decodes each request, walks the byte groups (release, volume,
  // note-on, program, bend, all-off) and scans the voices on stop-all.
  mvmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Voice state, instrument ROM, byte formatting and the output register.
  // The sequencer issues no new byte while one waits in the output register and the sink is not ready.
  mvmg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .func_i            (func_i),
    .voice_i           (voice_i),
    .value_i           (value_i),
    .current_channel_i (current_channel_i),
    .bank_i            (bank_q),
    .cmd_i             (cmd),
    .st_o              (st),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .midi_byte_o       (midi_byte_o),
    .last_byte_o       (last_byte_o),
    .channel_out_o     (channel_out_o)
  );

endmodule

// ===== dv/midi_voice_message_generator_test.sv =====
`timescale 1ns / 100ps

import mvmg_pkg::*;

typedef struct packed {
  bit [1:0] kind;
  bit [6:0] patch;
  bit [7:0] shift;
  bit [6:0] attack;
  bit [6:0] rel_vel;
  bit [6:0] level;
} patch_t;

localparam int PATCH_COUNT = 25;

// Instrument table for both banks: kind, patch, transpose, attack, release, level.
localparam patch_t PATCH_TABLE [2][PATCH_COUNT] = '{
  '{
    '{2'd1, 7'd34,  8'd0,  7'h7F, 7'h7F, 7'h5F}, '{2'd1, 7'd37,  8'd0,  7'h3F, 7'h3F, 7'h4F},
    '{2'd1, 7'd34,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd116, 8'd50, 7'h7F, 7'h7F, 7'h7F},
    '{2'd1, 7'd3,   8'd24, 7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd38,  8'd0,  7'h4F, 7'h4F, 7'h4F},
    '{2'd1, 7'd7,   8'd0,  7'h5F, 7'h5F, 7'h6F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h7F},
    '{2'd2, 7'd40,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd127, 8'd40, 7'h6F, 7'h6F, 7'h6F},
    '{2'd1, 7'd122, 8'd40, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd44,  8'd0,  7'h7F, 7'h7F, 7'h3F},
    '{2'd1, 7'd122, 8'd72, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd37,  8'd0,  7'h7F, 7'h7F, 7'h7F},
    '{2'd2, 7'd62,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd115, 8'd57, 7'h7F, 7'h7F, 7'h7F},
    '{2'd1, 7'd117, 8'd81, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd39,  8'd0,  7'h7F, 7'h7F, 7'h7F},
    '{2'd1, 7'd127, 8'd40, 7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd73,  8'd24, 7'h7F, 7'h20, 7'h7F},
    '{2'd1, 7'd118, 8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h5F},
    '{2'd2, 7'd56,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd38,  8'd0,  7'h7F, 7'h7F, 7'h3F},
    '{2'd1, 7'd11,  8'd36, 7'h7F, 7'h20, 7'h7F}
  },
  '{
    '{2'd1, 7'd28,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd69,  8'd0,  7'h3F, 7'h3F, 7'h3F},
    '{2'd1, 7'd28,  8'd0,  7'h7F, 7'h7F, 7'h78}, '{2'd1, 7'd117, 8'd50, 7'h7F, 7'h7F, 7'h7F},
    '{2'd1, 7'd7,   8'd24, 7'h5F, 7'h7F, 7'h6F}, '{2'd1, 7'd30,  8'd0,  7'h5F, 7'h5F, 7'h5F},
    '{2'd1, 7'd16,  8'd0,  7'h4F, 7'h4F, 7'h6F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h7F},
    '{2'd2, 7'd40,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd114, 8'd28, 7'h6F, 7'h6F, 7'h6F},
    '{2'd1, 7'd119, 8'd52, 7'h2F, 7'h7F, 7'h7F}, '{2'd2, 7'd44,  8'd0,  7'h7F, 7'h7F, 7'h3F},
    '{2'd1, 7'd124, 8'd60, 7'h7F, 7'h7F, 7'h5F}, '{2'd2, 7'd37,  8'd0,  7'h7F, 7'h7F, 7'h7F},
    '{2'd2, 7'd62,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd120, 8'd57, 7'h7F, 7'h7F, 7'h7F},
    '{2'd1, 7'd113, 8'd81, 7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd39,  8'd0,  7'h7F, 7'h7F, 7'h7F},
    '{2'd1, 7'd114, 8'd28, 7'h7F, 7'h7F, 7'h7F}, '{2'd1, 7'd47,  8'd25, 7'h7F, 7'h20, 7'h7F},
    '{2'd1, 7'd64,  8'd0,  7'h7F, 7'h7F, 7'h4F}, '{2'd2, 7'd42,  8'd0,  7'h7F, 7'h7F, 7'h5F},
    '{2'd2, 7'd56,  8'd0,  7'h7F, 7'h7F, 7'h7F}, '{2'd2, 7'd40,  8'd0,  7'h7F, 7'h7F, 7'h5F},
    '{2'd1, 7'd38,  8'd25, 7'h7F, 7'h20, 7'h7F}
  }
};

localparam bit BANK_GM  = 1'b0;
localparam bit BANK_ALT = 1'b1;

class midi_byte_scoreboard;
  typedef struct {
    bit [7:0] data;
    bit       last;
    bit [3:0] chan;
  } midi_byte_t;

  midi_byte_t expected_bytes[$];
  bit [7:0]   burst[$];

  bit       bank;
  bit [7:0] held[VOICE_COUNT];
  bit [3:0] voice_chan[VOICE_COUNT];
  bit [1:0] kind[VOICE_COUNT];
  bit [6:0] patch[VOICE_COUNT];
  bit [7:0] shift[VOICE_COUNT];
  bit [6:0] attack[VOICE_COUNT];
  bit [6:0] rel_vel[VOICE_COUNT];
  bit [6:0] level[VOICE_COUNT];

  int errors;
  int bytes_seen;
  int per_func[8];

  function new();
    bank = BANK_GM;
    foreach (held[i]) begin
      held[i]       = NO_NOTE;
      voice_chan[i] = '0;
      kind[i]       = KIND_SILENT;
      patch[i]      = '0;
      shift[i]      = '0;
      attack[i]     = '0;
      rel_vel[i]    = '0;
      level[i]      = '0;
    end
  endfunction

  function void set_bank(bit b);
    bank = b;
  endfunction

  // Send note-off for a held note (bit 7 clear) and forget it.
  function void drop_note(int v, bit [3:0] ch);
    if (held[v][7] == 1'b0) begin
      burst.push_back(ST_NOTE_OFF | 8'(ch));
      burst.push_back(held[v]);
      burst.push_back(8'(rel_vel[v]));
      held[v] = NO_NOTE;
    end
  endfunction

  // Work out the bytes one accepted request causes and queue them.
  function void note_request(bit [2:0] fn, bit [2:0] vc, bit [7:0] val, bit [3:0] cur);
    bit [3:0]   ch_out;
    bit [3:0]   ch;
    bit [7:0]   note;
    patch_t     p;
    midi_byte_t e;
    ch_out = cur;
    burst.delete();
    per_func[fn]++;
    if (int'(vc) < VOICE_COUNT) begin
      case (fn)
        FN_NOTE_ON: begin
          note = val + shift[vc];
          drop_note(vc, cur);
          if (kind[vc] != KIND_SILENT) begin
            if (kind[vc] == KIND_PERC) begin
              note = {1'b0, patch[vc]};
              burst.push_back(ST_CONTROL | 8'(cur));
              burst.push_back(CTRL_VOLUME);
              burst.push_back(8'(level[vc]));
            end
            held[vc] = note[7] ? NO_NOTE : note;
            burst.push_back(ST_NOTE_ON | 8'(cur));
            burst.push_back(note);
            burst.push_back(8'(attack[vc]));
          end
        end
        FN_NOTE_OFF: drop_note(vc, cur);
        FN_INSTR: begin
          if (int'(val) < INSTRUMENT_COUNT && int'(val) < PATCH_COUNT) begin
            p = PATCH_TABLE[bank][val];
            drop_note(vc, cur);
            kind[vc]    = p.kind;
            patch[vc]   = p.patch;
            shift[vc]   = p.shift;
            attack[vc]  = p.attack;
            rel_vel[vc] = p.rel_vel;
            level[vc]   = p.level;
            if (p.kind == KIND_MELODIC) begin
              ch = 4'(vc) + 4'(bank);
              burst.push_back(ST_PROGRAM | 8'(ch));
              burst.push_back(8'(p.patch));
              burst.push_back(ST_CONTROL | 8'(ch));
              burst.push_back(CTRL_VOLUME);
              burst.push_back(8'(p.level));
            end else begin
              ch = PERC_CHANNEL;
            end
            voice_chan[vc] = ch;
            ch_out = ch;
          end
        end
        FN_PLAY: begin
          for (int i = 0; i < 8; i++) begin
            burst.push_back(ST_BEND + 8'(i));
            burst.push_back(8'h00);
            burst.push_back(BEND_CENTRE);
          end
        end
        FN_STOP: begin
          for (int i = 0; i < VOICE_COUNT; i++) drop_note(i, voice_chan[i]);
          burst.push_back(ST_CONTROL);
          burst.push_back(CTRL_ALL_OFF);
          burst.push_back(8'h00);
        end
        default: ;
      endcase
    end
    foreach (burst[k]) begin
      e.data = burst[k];
      e.last = (k == burst.size() - 1);
      e.chan = ch_out;
      expected_bytes.push_back(e);
    end
  endfunction

  task report(string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task check_byte(bit [7:0] data, bit last, bit [3:0] chan);
    midi_byte_t e;
    bytes_seen++;
    if (expected_bytes.size() == 0) begin
      report($sformatf("byte %02h arrived with none pending", data));
    end else begin
      e = expected_bytes.pop_front();
      if (data != e.data)
        report($sformatf("midi_byte %02h, want %02h", data, e.data));
      if (last != e.last)
        report($sformatf("last_byte %0b, want %0b (byte %02h)", last, e.last, e.data));
      if (chan != e.chan)
        report($sformatf("channel_out %0d, want %0d (byte %02h)", chan, e.chan, e.data));
    end
  endtask
endclass

module midi_voice_message_generator_test;

  // Spare command codes the block must swallow without output.
  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST  = 3'd7;
  // Cycles to let the block settle once nothing is pending: covers a request
  // that sends nothing and the output register.
  localparam int SETTLE_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  func_i;
  logic [2:0]  voice_i;
  logic [7:0]  value_i;
  logic [3:0]  current_channel_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  midi_byte_o;
  logic        last_byte_o;
  logic [3:0]  channel_out_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  midi_voice_message_generator dut (.*);

  midi_byte_scoreboard sb;
  bit quiet;         // no idling on either side when set
  int spare_reqs;    // requests the block should ignore

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("timeout with %0d bytes still pending", sb.expected_bytes.size());
    $display("status: fail");
    $finish;
  end

  // Sink side: drop ready in random bursts.
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check every byte that leaves the block.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_byte(midi_byte_o, last_byte_o, channel_out_o);
  end

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the bank register, read it back, and track it in the predictor.
  task automatic set_bank(input bit b);
    logic [2:0]  addr;
    logic [31:0] rd;
    addr = 3'(4 * int'(REG_IDX_BANK));
    apb_xfer(1'b1, addr, 32'(b), rd);
    sb.set_bank(b);
    apb_xfer(1'b0, addr, '0, rd);
    if (rd !== 32'(b)) sb.report($sformatf("bank readback %08h, want %0d", rd, b));
  endtask

  // Offer one request, with an optional leading gap, and hold it until taken.
  task automatic send(input logic [2:0] fn, input logic [2:0] vc, input logic [7:0] val,
                      input logic [3:0] ch);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    func_i            <= fn;
    voice_i           <= vc;
    value_i           <= val;
    current_channel_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(fn, vc, val, ch);
  endtask

  // Request on a voice using the channel the caller holds for it.
  task automatic send_on(input logic [2:0] fn, input logic [2:0] vc, input logic [7:0] val);
    send(fn, vc, val, sb.voice_chan[vc]);
  endtask

  // Drop valid, wait for every pending byte, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: loads, note-ons and note-offs on random voices, plus
  // stop-all, play-start and a share of commands the block should drop.
  task automatic run_mix(input int target);
    int         done;
    int         pick;
    logic [2:0] vc;
    logic [7:0] val;
    logic [3:0] ch;
    done = 0;
    while (done < target) begin
      vc   = 3'($urandom_range(0, VOICE_COUNT - 1));
      pick = $urandom_range(0, 99);
      ch   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : sb.voice_chan[vc];
      case ($urandom_range(0, 9))
        0:       val = 8'h00;
        1:       val = 8'hFF;
        default: val = 8'($urandom);
      endcase
      if (pick < 20) begin
        send(FN_INSTR, vc, 8'($urandom_range(0, PATCH_COUNT - 1)), ch);
        done++;
      end else if (pick < 62) begin
        send(FN_NOTE_ON, vc, val, ch);
        done++;
      end else if (pick < 78) begin
        send(FN_NOTE_OFF, vc, val, ch);
        done++;
      end else if (pick < 83) begin
        send(FN_PLAY, vc, val, ch);
        done++;
      end else if (pick < 88) begin
        send(FN_STOP, vc, val, ch);
        done++;
      end else if (pick < 94) begin
        // index past the table: ignored
        send(FN_INSTR, vc, 8'($urandom_range(PATCH_COUNT, 255)), ch);
      end else begin
        send(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), vc, 8'($urandom),
             4'($urandom));
        spare_reqs++;
      end
    end
  endtask

  initial begin
    sb                = new();
    quiet             = 1'b0;
    spare_reqs        = 0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    func_i            = FN_NOTE_ON;
    voice_i           = '0;
    value_i           = '0;
    current_channel_i = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, general midi bank.
    set_bank(BANK_GM);
    send(FN_PLAY, 3'd0, 8'h00, 4'd0);         // centre bend on channels 0..7
    send(FN_NOTE_ON, 3'd0, 8'd60, 4'd15);     // silent voice, nothing held: no bytes
    send(FN_INSTR, 3'd0, 8'd0, 4'd0);         // first instrument, melodic
    send_on(FN_NOTE_ON, 3'd0, 8'd0);          // lowest note
    send_on(FN_NOTE_ON, 3'd0, 8'd127);        // release note 0, play 127
    send_on(FN_NOTE_ON, 3'd0, 8'd255);        // sent but stored as not held
    send_on(FN_NOTE_OFF, 3'd0, 8'd0);         // nothing held: no bytes
    send(FN_INSTR, 3'd7, 8'd24, 4'd15);       // last instrument, transpose 36
    send_on(FN_NOTE_ON, 3'd7, 8'd100);        // note wraps past 127: not held
    send_on(FN_NOTE_ON, 3'd7, 8'd91);         // lands on 127: held
    send(FN_INSTR, 3'd3, 8'd7, 4'd3);         // percussive: channel 9, no bytes
    send_on(FN_NOTE_ON, 3'd3, 8'd55);         // volume first, patch as the note
    send_on(FN_NOTE_OFF, 3'd3, 8'd0);
    send_on(FN_INSTR, 3'd7, 8'd25);           // first index past the table: ignored
    send_on(FN_INSTR, 3'd7, 8'd255);          // top index: ignored
    send(FN_SPARE_FIRST, 3'd2, 8'hA5, 4'd5);
    send(3'd6, 3'd4, 8'h5A, 4'd10);
    send(FN_SPARE_LAST, 3'd7, 8'hFF, 4'd15);
    send(FN_INSTR, 3'd7, 8'd13, 4'd7);        // percussive load releases held 127
    send_on(FN_NOTE_ON, 3'd5, 8'd0);
    send(FN_NOTE_OFF, 3'd7, 8'd0, 4'd2);      // wrong caller channel, nothing held
    send_on(FN_NOTE_ON, 3'd7, 8'd0);
    send(FN_STOP, 3'd0, 8'h00, 4'd12);        // release every voice, all notes off
    drain();

    // Alternate bank: melodic channel shifts up by one.
    set_bank(BANK_ALT);
    send(FN_INSTR, 3'd7, 8'd20, 4'd0);        // melodic on channel 8
    send_on(FN_NOTE_ON, 3'd7, 8'd64);
    send(FN_INSTR, 3'd1, 8'd23, 4'd1);        // percussive entry differs per bank
    run_mix(55);
    drain();

    set_bank(BANK_GM);
    run_mix(55);
    drain();

    // Last stretch: both sides run flat out.
    set_bank(BANK_ALT);
    quiet = 1'b1;
    run_mix(45);
    drain();

    $display("covered %0d note on, %0d note off, %0d instrument, %0d play, %0d stop requests",
             sb.per_func[FN_NOTE_ON], sb.per_func[FN_NOTE_OFF], sb.per_func[FN_INSTR],
             sb.per_func[FN_PLAY], sb.per_func[FN_STOP]);
    $display("plus %0d spare codes; %0d MIDI bytes checked over both banks, %0d mismatches",
             spare_reqs, sb.bytes_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== midi_voice_message_generator.f =====
rtl/mvmg_pkg.sv
rtl/mvmg_dp.sv
rtl/mvmg_ctrl.sv
rtl/midi_voice_message_generator.sv
dv/midi_voice_message_generator_test.sv
